// ===== design/twrd_pkg.sv =====
// Package for the two-way-ranging distance block: shared widths, constants,
// register indexes and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package twrd_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int TS_A_W  = 32;
	localparam int TS_B_W  = 40;
	localparam int WIDE_W  = 64;
	localparam int DIST_W  = 20;
	localparam int SCALE_W = 24;
	localparam int TOL_W   = 16;
	localparam int STEP_W  = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;

	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd307387;
	localparam logic [TOL_W-1:0]   TOL_RST   = 16'd250;

	// last step of the shift-add multiplier and of the divider
	localparam logic [STEP_W-1:0] MUL_LAST_STEP = 6'd39;
	localparam logic [STEP_W-1:0] DIV_LAST_STEP = 6'd63;

	typedef struct packed {
		logic take;
		logic load_iv;
		logic mul_set1;
		logic mul_set2;
		logic mul_set3;
		logic mul_step;
		logic div_set;
		logic div_step;
		logic chk;
		logic fault_zero;
		logic scl_done;
		logic clr;
		logic store;
		logic v_init;
		logic rd_outer;
		logic rd_inner;
		logic rd_use;
		logic v_adv;
		logic v_cand;
		logic v_b;
		logic v_res;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic den_zero;
		logic mul_last;
		logic div_last;
		logic need_scale;
		logic a_zero;
		logic best_half;
		logic cnt_done;
		logic k_more;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/twrd_ctrl.sv =====
// Sequencer of the ranging block: walks one request through products, division,
// scaling, history store and vote. Uses twrd_pkg command and status types.
`default_nettype none

module twrd_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              out_free,
	input  twrd_pkg::sts_t   sts,
	output logic             in_stall,
	output twrd_pkg::cmd_t   cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_LOAD = 5'd1;
	localparam logic [4:0] S_SET1 = 5'd2;
	localparam logic [4:0] S_MUL1 = 5'd3;
	localparam logic [4:0] S_SET2 = 5'd4;
	localparam logic [4:0] S_MUL2 = 5'd5;
	localparam logic [4:0] S_DIVS = 5'd6;
	localparam logic [4:0] S_DIV  = 5'd7;
	localparam logic [4:0] S_CHK  = 5'd8;
	localparam logic [4:0] S_MUL3 = 5'd9;
	localparam logic [4:0] S_SCL  = 5'd10;
	localparam logic [4:0] S_STOR = 5'd11;
	localparam logic [4:0] S_VINI = 5'd12;
	localparam logic [4:0] S_VOUT = 5'd13;
	localparam logic [4:0] S_VA   = 5'd14;
	localparam logic [4:0] S_VBRD = 5'd15;
	localparam logic [4:0] S_VB   = 5'd16;
	localparam logic [4:0] S_VFIN = 5'd17;
	localparam logic [4:0] S_VRES = 5'd18;
	localparam logic [4:0] S_DONE = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_n;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.kind) begin
					cmd.clr = 1'b1;
					state_n = S_VINI;
				end else begin
					cmd.load_iv = 1'b1;
					state_n     = S_SET1;
				end
			end
			S_SET1: begin
				cmd.mul_set1 = 1'b1;
				state_n      = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_n = S_SET2;
			end
			S_SET2: begin
				cmd.mul_set2 = 1'b1;
				state_n      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_n = S_DIVS;
			end
			S_DIVS: begin
				if (sts.den_zero) begin
					cmd.fault_zero = 1'b1;
					state_n        = S_STOR;
				end else begin
					cmd.div_set = 1'b1;
					state_n     = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_n = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (sts.need_scale) begin
					cmd.mul_set3 = 1'b1;
					state_n      = S_MUL3;
				end else begin
					state_n = S_STOR;
				end
			end
			S_MUL3: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_n = S_SCL;
			end
			S_SCL: begin
				cmd.scl_done = 1'b1;
				state_n      = S_STOR;
			end
			S_STOR: begin
				cmd.store = 1'b1;
				state_n   = S_VINI;
			end
			S_VINI: begin
				cmd.v_init = 1'b1;
				state_n    = S_VOUT;
			end
			S_VOUT: begin
				if (sts.cnt_done) begin
					state_n = S_VFIN;
				end else begin
					cmd.rd_outer = 1'b1;
					state_n      = S_VA;
				end
			end
			S_VA: begin
				if (sts.a_zero) begin
					cmd.v_adv = 1'b1;
					state_n   = S_VOUT;
				end else if (sts.best_half) begin
					state_n = S_VFIN;
				end else begin
					cmd.v_cand = 1'b1;
					state_n    = S_VBRD;
				end
			end
			S_VBRD: begin
				if (sts.k_more) begin
					cmd.rd_inner = 1'b1;
					state_n      = S_VB;
				end else begin
					cmd.v_adv = 1'b1;
					state_n   = S_VOUT;
				end
			end
			S_VB: begin
				cmd.v_b = 1'b1;
				state_n = S_VBRD;
			end
			S_VFIN: begin
				cmd.rd_use = 1'b1;
				state_n    = S_VRES;
			end
			S_VRES: begin
				cmd.v_res = 1'b1;
				state_n   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== design/twrd_dp.sv =====
// Datapath of the ranging block: interval registers, shared shift-add multiplier,
// restoring divider, distance history memory and vote counters. Uses twrd_pkg.
`default_nettype none

module twrd_dp #(
	parameter int HISTORY_DEPTH = twrd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  twrd_pkg::cmd_t                     cmd,
	input  wire                                kind,
	input  wire  [twrd_pkg::TS_A_W-1:0]        poll_tx_time,
	input  wire  [twrd_pkg::TS_A_W-1:0]        reply_rx_time,
	input  wire  [twrd_pkg::TS_A_W-1:0]        final_tx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]        poll_rx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]        reply_tx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]        final_rx_time,
	input  wire  [twrd_pkg::SCALE_W-1:0]       scale,
	input  wire  [twrd_pkg::TOL_W-1:0]         tol,
	output twrd_pkg::sts_t                     sts,
	output logic [twrd_pkg::DIST_W-1:0]        new_dist,
	output logic [twrd_pkg::DIST_W-1:0]        voted,
	output logic                               fault
);

	localparam int SW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int AW = twrd_pkg::TS_A_W;
	localparam int BW = twrd_pkg::TS_B_W;
	localparam int WW = twrd_pkg::WIDE_W;
	localparam int DW = twrd_pkg::DIST_W;
	localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);

	// captured request
	logic          kind_q;
	logic [AW-1:0] ptx_q, rrx_q, ftx_q;
	logic [BW-1:0] prx_q, rtx_q, frx_q;

	// intervals and arithmetic
	logic [AW-1:0] ra_q, da_q;
	logic [BW-1:0] rb_q, db_q;
	logic [WW-1:0] den_q, acc_q, mcand_q, rem_q, quo_q;
	logic [BW-1:0] mplier_q;
	logic [twrd_pkg::STEP_W-1:0] step_q;
	logic nneg_q, dneg_q;
	logic [DW-1:0] dist_q, voted_q;
	logic fault_q;

	// history and vote
	logic [DW-1:0] mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] vld_q;
	logic [DW-1:0] rd_q;
	logic          rdv_q;
	logic [SW-1:0] newest_q, outer_q, inner_q, use_q;
	logic [CW-1:0] cnt_q, k_q, best_q, agree_q;
	logic [DW-1:0] a_q;

	logic [WW-1:0] ra_x, da_x, rb_x, db_x;
	logic [WW-1:0] addend, rem_sh;
	logic          rem_ge;
	logic [SW-1:0] wslot, raddr, outer_nx, inner_nx;
	logic [DW-1:0] rdata, diff;
	logic          hit;
	logic [CW-1:0] agree_n;
	logic          q_bad, q_big;

	assign ra_x = {{(WW-AW){ra_q[AW-1]}}, ra_q};
	assign da_x = {{(WW-AW){da_q[AW-1]}}, da_q};
	assign rb_x = {{(WW-BW){rb_q[BW-1]}}, rb_q};
	assign db_x = {{(WW-BW){db_q[BW-1]}}, db_q};

	// multiplier bit 39 carries negative weight
	always_comb begin
		if (!mplier_q[0]) begin
			addend = '0;
		end else if (step_q == twrd_pkg::MUL_LAST_STEP) begin
			addend = -mcand_q;
		end else begin
			addend = mcand_q;
		end
	end

	assign rem_sh = {rem_q[WW-2:0], quo_q[WW-1]};
	assign rem_ge = (rem_sh >= den_q);

	assign q_bad = (quo_q == '0) || (nneg_q != dneg_q) || quo_q[WW-1] || (scale == '0);
	assign q_big = (quo_q[WW-1:BW] != '0);

	// capture, intervals, multiply, divide, scale
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= kind;
			ptx_q  <= poll_tx_time;
			rrx_q  <= reply_rx_time;
			ftx_q  <= final_tx_time;
			prx_q  <= poll_rx_time;
			rtx_q  <= reply_tx_time;
			frx_q  <= final_rx_time;
		end
		if (cmd.load_iv) begin
			ra_q <= rrx_q - ptx_q;
			da_q <= ftx_q - rrx_q;
			rb_q <= frx_q - rtx_q;
			db_q <= rtx_q - prx_q;
		end
		if (cmd.mul_set1) begin
			den_q    <= ra_x + rb_x + da_x + db_x;
			acc_q    <= '0;
			mcand_q  <= ra_x;
			mplier_q <= rb_q;
			step_q   <= '0;
		end else if (cmd.mul_set2) begin
			mcand_q  <= -da_x;
			mplier_q <= db_q;
			step_q   <= '0;
		end else if (cmd.mul_set3) begin
			acc_q    <= '0;
			mcand_q  <= {{(WW-BW){1'b0}}, quo_q[BW-1:0]};
			mplier_q <= {{(BW-twrd_pkg::SCALE_W){1'b0}}, scale};
			step_q   <= '0;
		end else if (cmd.mul_step) begin
			acc_q    <= acc_q + addend;
			mcand_q  <= {mcand_q[WW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[BW-1:1]};
			step_q   <= step_q + 1'b1;
		end else if (cmd.div_set) begin
			nneg_q <= acc_q[WW-1];
			dneg_q <= den_q[WW-1];
			quo_q  <= acc_q[WW-1] ? -acc_q : acc_q;
			den_q  <= den_q[WW-1] ? -den_q : den_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_sh - den_q : rem_sh;
			quo_q  <= {quo_q[WW-2:0], rem_ge};
			step_q <= step_q + 1'b1;
		end
		if (cmd.load_iv || cmd.clr) begin
			dist_q  <= '0;
			fault_q <= 1'b0;
		end else if (cmd.fault_zero) begin
			dist_q  <= '0;
			fault_q <= 1'b1;
		end else if (cmd.chk) begin
			dist_q <= q_bad ? '0 : twrd_pkg::DIST_MAX;
		end else if (cmd.scl_done) begin
			dist_q <= (acc_q[WW-1:16] > {{(WW-16-DW){1'b0}}, twrd_pkg::DIST_MAX})
			          ? twrd_pkg::DIST_MAX : acc_q[16+DW-1:16];
		end
		if (cmd.v_res) voted_q <= rdata;
	end

	assign wslot    = (newest_q == SLOT_LAST) ? '0 : newest_q + 1'b1;
	assign outer_nx = (outer_q == SLOT_LAST) ? '0 : outer_q + 1'b1;
	assign inner_nx = (inner_q == SLOT_LAST) ? '0 : inner_q + 1'b1;

	always_comb begin
		if (cmd.rd_inner) begin
			raddr = inner_q;
		end else if (cmd.rd_use) begin
			raddr = use_q;
		end else begin
			raddr = outer_q;
		end
	end

	// history memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.store) mem[wslot] <= dist_q;
		rd_q  <= mem[raddr];
		rdv_q <= vld_q[raddr];
	end

	assign rdata   = rdv_q ? rd_q : '0;
	assign diff    = (a_q > rdata) ? a_q - rdata : rdata - a_q;
	assign hit     = (diff <= {{(DW-twrd_pkg::TOL_W){1'b0}}, tol});
	assign agree_n = agree_q + 1'b1;

	// ring pointer, valid bits and vote counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			newest_q <= '0;
			outer_q  <= '0;
			inner_q  <= '0;
			use_q    <= '0;
			cnt_q    <= '0;
			k_q      <= '0;
			best_q   <= '0;
			agree_q  <= '0;
			a_q      <= '0;
		end else begin
			if (cmd.clr) begin
				vld_q    <= '0;
				newest_q <= '0;
			end else if (cmd.store) begin
				vld_q[wslot] <= 1'b1;
				newest_q     <= wslot;
			end
			if (cmd.v_init) begin
				outer_q <= newest_q;
				use_q   <= newest_q;
				best_q  <= '0;
				cnt_q   <= '0;
			end
			if (cmd.v_adv) begin
				outer_q <= outer_nx;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (cmd.v_cand) begin
				a_q     <= rdata;
				inner_q <= outer_nx;
				k_q     <= cnt_q;
				agree_q <= '0;
			end
			if (cmd.v_b) begin
				inner_q <= inner_nx;
				k_q     <= k_q + 1'b1;
				if (hit) begin
					agree_q <= agree_n;
					if (agree_n > best_q) begin
						best_q <= agree_n;
						use_q  <= outer_q;
					end
				end
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.kind       = kind_q;
		sts.den_zero   = (den_q == '0);
		sts.mul_last   = (step_q == twrd_pkg::MUL_LAST_STEP);
		sts.div_last   = (step_q == twrd_pkg::DIV_LAST_STEP);
		sts.need_scale = !q_bad && !q_big;
		sts.a_zero     = (rdata == '0);
		sts.best_half  = (best_q >= CW'(HISTORY_DEPTH / 2));
		sts.cnt_done   = (cnt_q == CW'(HISTORY_DEPTH));
		sts.k_more     = (k_q < CW'(HISTORY_DEPTH - 1));
	end

	assign new_dist = dist_q;
	assign voted    = voted_q;
	assign fault    = fault_q;

	a_newest_range: assert property (@(posedge clk) disable iff (!arst_n)
		newest_q <= SLOT_LAST)
		else $error("newest slot out of ring");

	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> vld_q[newest_q])
		else $error("stored slot not marked valid");

	a_compare_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.v_b |-> (k_q < CW'(HISTORY_DEPTH - 1)))
		else $error("vote compare beyond ring");

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_q < CW'(HISTORY_DEPTH))
		else $error("agreement count too large");

endmodule

`default_nettype wire

// ===== design/twr_distance_with_majority_vote.sv =====
// Double-sided two-way-ranging distance with a majority-voted history.
// Input channel (in_valid/in_stall): one request is a clear (kind=1) or one
// exchange of six timestamps (kind=0). Output channel (out_valid/out_stall):
// one result per request: new_distance_mm, voted_distance_mm, divide_fault.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 mm_per_tick_q16,
// index 1 tolerance_mm; write only while no request is in flight.
// An exchange runs two 40-step shift-add products, a 64-step restoring divide
// and, when the quotient is valid and fits 40 bits, a 40-step scaling product,
// each after a setup state; a zero divisor skips the divide and the scaling, a
// clear goes straight to the vote. The vote reads the single history port.
// One request is in flight at a time.
// The finished result sits in an output register; a new request is accepted
// while it waits, and a second result waits in the sequencer until the first
// is taken.
// Reset: history empty (reads as zero), ring pointer zero, registers at their
// reset values, no result pending.
// Depends on twrd_pkg, twrd_ctrl, twrd_dp.
`default_nettype none

module twr_distance_with_majority_vote #(
	parameter int HISTORY_DEPTH = twrd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 kind,
	input  wire  [twrd_pkg::TS_A_W-1:0]         poll_tx_time,
	input  wire  [twrd_pkg::TS_A_W-1:0]         reply_rx_time,
	input  wire  [twrd_pkg::TS_A_W-1:0]         final_tx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]         poll_rx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]         reply_tx_time,
	input  wire  [twrd_pkg::TS_B_W-1:0]         final_rx_time,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [twrd_pkg::DIST_W-1:0]         new_distance_mm,
	output logic [twrd_pkg::DIST_W-1:0]         voted_distance_mm,
	output logic                                divide_fault,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [twrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [twrd_pkg::SCALE_W-1:0]        cfg_data
);

	twrd_pkg::cmd_t cmd;
	twrd_pkg::sts_t sts;

	logic [twrd_pkg::SCALE_W-1:0] scale_q;
	logic [twrd_pkg::TOL_W-1:0]   tol_q;
	logic [twrd_pkg::DIST_W-1:0]  new_dist, voted;
	logic                         fault;
	logic                         out_valid_q;
	logic                         out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= twrd_pkg::SCALE_RST;
			tol_q   <= twrd_pkg::TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				twrd_pkg::REG_SCALE: scale_q <= cfg_data;
				twrd_pkg::REG_TOL:   tol_q   <= cfg_data[twrd_pkg::TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	twrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	twrd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.poll_tx_time  (poll_tx_time),
		.reply_rx_time (reply_rx_time),
		.final_tx_time (final_tx_time),
		.poll_rx_time  (poll_rx_time),
		.reply_tx_time (reply_tx_time),
		.final_rx_time (final_rx_time),
		.scale         (scale_q),
		.tol           (tol_q),
		.sts           (sts),
		.new_dist      (new_dist),
		.voted         (voted),
		.fault         (fault)
	);

	// output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			new_distance_mm   <= new_dist;
			voted_distance_mm <= voted;
			divide_fault      <= fault;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for twr_distance_with_majority_vote: random and directed ranging requests,
// predicted distances and votes checked in order. Depends on twrd_pkg and the block.
`default_nettype none

typedef struct {
	bit        kind;
	bit [31:0] ptx, rrx, ftx;
	bit [39:0] prx, rtx, frx;
} xchg_t;

typedef struct {
	bit [19:0] dist_mm;
	bit [19:0] voted;
	bit        fault;
} range_res_t;

class RangeScoreboard;
	bit [19:0]  hist[10];
	int         slot;
	bit [23:0]  scale;
	bit [15:0]  tol;
	range_res_t expected_q[$];
	int         errors;
	int         n_req, n_res, n_clear, n_fault, n_voted;

	function void reset_state();
		foreach (hist[i]) hist[i] = 0;
		slot = 0;
		scale = twrd_pkg::SCALE_RST;
		tol = twrd_pkg::TOL_RST;
	endfunction

	// time of flight in mm, with divide fault flag
	function bit [19:0] tof_mm(xchg_t x, output bit fault);
		bit [31:0] d32a, d32b;
		bit [39:0] d40a, d40b;
		bit [63:0] ra, da, rb, db, num, den, nmag, dmag, q;
		bit        nneg, dneg;
		d32a = x.rrx - x.ptx;
		d32b = x.ftx - x.rrx;
		d40a = x.frx - x.rtx;
		d40b = x.rtx - x.prx;
		ra = {{32{d32a[31]}}, d32a};
		da = {{32{d32b[31]}}, d32b};
		rb = {{24{d40a[39]}}, d40a};
		db = {{24{d40b[39]}}, d40b};
		num = ra * rb - da * db;
		den = ra + rb + da + db;
		fault = 0;
		if (den == 0) begin
			fault = 1;
			return 0;
		end
		nneg = num[63];
		dneg = den[63];
		nmag = nneg ? -num : num;
		dmag = dneg ? -den : den;
		q = nmag / dmag;
		if (q == 0 || nneg != dneg || q[63]) return 0;
		if (scale == 0) return 0;
		if (q >= 64'd1 << 40) return twrd_pkg::DIST_MAX;
		q = (q * scale) >> 16;
		return (q > twrd_pkg::DIST_MAX) ? twrd_pkg::DIST_MAX : q[19:0];
	endfunction

	// majority vote over the ring, newest entry first
	function bit [19:0] vote();
		int        outer, best, pick, inner, agree;
		bit [19:0] a, b, d;
		outer = slot;
		best = 0;
		pick = slot;
		for (int cnt = 0; cnt < 10; cnt++) begin
			a = hist[outer];
			if (a != 0) begin
				if (best >= 5) break;
				inner = outer;
				agree = 0;
				for (int k = cnt; k < 9; k++) begin
					inner = (inner + 1) % 10;
					b = hist[inner];
					d = (a > b) ? a - b : b - a;
					if (d <= tol) begin
						agree++;
						if (agree > best) begin
							best = agree;
							pick = outer;
						end
					end
				end
			end
			outer = (outer + 1) % 10;
		end
		if (best > 0) n_voted++;
		return hist[pick];
	endfunction

	function void note_request(xchg_t x);
		range_res_t r;
		r.dist_mm = 0;
		r.fault = 0;
		n_req++;
		if (x.kind) begin
			foreach (hist[i]) hist[i] = 0;
			slot = 0;
			n_clear++;
		end else begin
			r.dist_mm = tof_mm(x, r.fault);
			slot = (slot + 1) % 10;
			hist[slot] = r.dist_mm;
			if (r.fault) n_fault++;
		end
		r.voted = vote();
		expected_q.push_back(r);
	endfunction

	function void check_result(range_res_t got);
		range_res_t e;
		n_res++;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected");
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (got.dist_mm != e.dist_mm) begin
			$error("new_distance_mm expected %0d got %0d", e.dist_mm, got.dist_mm);
			errors++;
		end
		if (got.voted != e.voted) begin
			$error("voted_distance_mm expected %0d got %0d", e.voted, got.voted);
			errors++;
		end
		if (got.fault != e.fault) begin
			$error("divide_fault expected %0d got %0d", e.fault, got.fault);
			errors++;
		end
	endfunction
endclass

module tb_top;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic kind;
	logic [31:0] poll_tx_time, reply_rx_time, final_tx_time;
	logic [39:0] poll_rx_time, reply_tx_time, final_rx_time;
	logic [twrd_pkg::DIST_W-1:0] new_distance_mm, voted_distance_mm;
	logic divide_fault;
	logic [twrd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [twrd_pkg::SCALE_W-1:0] cfg_data;

	RangeScoreboard sb;
	bit  hold_req;
	bit  busy_mode;
	int  idle_cycles;
	int  base_ticks;

	twr_distance_with_majority_vote DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		cfg_valid = 0;
		kind = 0;
		{poll_tx_time, reply_rx_time, final_tx_time} = '0;
		{poll_rx_time, reply_tx_time, final_rx_time} = '0;
		cfg_index = twrd_pkg::REG_SCALE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// note accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request('{kind, poll_tx_time, reply_rx_time, final_tx_time,
				poll_rx_time, reply_tx_time, final_rx_time});
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{new_distance_mm, voted_distance_mm, divide_fault});
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 6000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (busy_mode || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stall: random, with one long hold-off on request
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (700) @(posedge clk);
				hold_req = 0;
			end
			out_stall <= !busy_mode && ($urandom_range(0, 99) < 30 ||
				(out_stall && $urandom_range(0, 99) < 85));
		end
	end

	task automatic send(xchg_t x);
		int g;
		in_valid <= 1;
		kind <= x.kind;
		poll_tx_time <= x.ptx;
		reply_rx_time <= x.rrx;
		final_tx_time <= x.ftx;
		poll_rx_time <= x.prx;
		reply_tx_time <= x.rtx;
		final_rx_time <= x.frx;
		do @(posedge clk); while (in_stall);
		g = rand_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [twrd_pkg::CFG_IDX_W-1:0] idx,
		logic [twrd_pkg::SCALE_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == twrd_pkg::REG_SCALE) sb.scale = val;
		else sb.tol = val[twrd_pkg::TOL_W-1:0];
	endtask

	function automatic xchg_t noise();
		xchg_t x;
		x.kind = 1'($urandom_range(0, 1));
		x.ptx = $urandom;
		x.rrx = $urandom;
		x.ftx = $urandom;
		x.prx = {8'($urandom_range(0, 255)), $urandom};
		x.rtx = {8'($urandom_range(0, 255)), $urandom};
		x.frx = {8'($urandom_range(0, 255)), $urandom};
		return x;
	endfunction

	// consistent exchange around a flight time, with reply delays on both sides
	function automatic xchg_t exchange(int tof);
		xchg_t x;
		bit [31:0] ra, da, db, rb;
		db = $urandom_range(1000, 1 << 20);
		da = $urandom_range(1000, 1 << 20);
		ra = 2 * tof + db;
		rb = 2 * tof + da;
		x.kind = 0;
		x.ptx = $urandom;
		x.rrx = x.ptx + ra;
		x.ftx = x.rrx + da;
		x.prx = {8'($urandom_range(0, 255)), $urandom};
		x.rtx = x.prx + db;
		x.frx = x.rtx + rb;
		return x;
	endfunction

	task automatic random_phase(int n, bit pressure);
		xchg_t x;
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				busy_mode = ($urandom_range(0, 3) == 0);
				base_ticks = $urandom_range(0, 3) == 0 ? $urandom_range(0, 300000)
					: $urandom_range(50, 20000);
			end
			if (pressure && i == 10) hold_req = 1;
			if (i == n / 2) begin
				in_valid <= 0;
				while (sb.expected_q.size() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 75) x = exchange(base_ticks + $urandom_range(0, 40));
			else if (r < 80) x = exchange(-$urandom_range(1, 5000));
			else if (r < 83) begin
				x = noise();
				x.kind = 1;
			end else x = noise();
			send(x);
		end
	endtask

	initial begin
		xchg_t x;
		hold_req = 0;
		busy_mode = 0;
		base_ticks = 1000;
		@(posedge arst_n);
		@(posedge clk);

		// directed: zero divisor, extremes, clear, negative and saturating flight
		x = '{0, 0, 0, 0, 0, 0, 0};
		send(x);
		x = '{0, '1, '1, '1, '1, '1, '1};
		send(x);
		x = '{1, '1, '1, '1, '1, '1, '1};
		send(x);
		send(exchange(1000));
		send(exchange(1001));
		send(exchange(1005));
		send(exchange(-200));
		send(exchange(1000000));
		send(exchange(0));
		x = '{1, 0, 0, 0, 0, 0, 0};
		send(x);
		// remote side wraps past 2^32, local side past 2^40
		x = exchange(3000);
		x.ptx = 32'hFFFF_FFF0;
		x.rrx = x.ptx + 32'd600000;
		x.ftx = x.rrx + 32'd100000;
		x.prx = 40'hFF_FFFF_FFF0;
		x.rtx = x.prx + 40'd594000;
		x.frx = x.rtx + 40'd106000;
		send(x);
		for (int i = 0; i < 8; i++) send(exchange(2000 + i));
		drain();

		write_reg(twrd_pkg::REG_SCALE, 24'd0);
		write_reg(twrd_pkg::REG_TOL, 24'd0);
		random_phase(120, 0);
		drain();
		write_reg(twrd_pkg::REG_SCALE, 24'hFFFFFF);
		write_reg(twrd_pkg::REG_TOL, 24'h00FFFF);
		random_phase(150, 1);
		drain();
		write_reg(twrd_pkg::REG_SCALE, 24'd65536);
		write_reg(twrd_pkg::REG_TOL, 24'd0);
		random_phase(150, 0);
		drain();
		write_reg(twrd_pkg::REG_SCALE, 24'($urandom_range(1, 24'hFFFFFF)));
		write_reg(twrd_pkg::REG_TOL, 24'($urandom_range(0, 2000)));
		random_phase(150, 0);
		drain();
		write_reg(twrd_pkg::REG_SCALE, twrd_pkg::SCALE_RST);
		write_reg(twrd_pkg::REG_TOL, 24'(twrd_pkg::TOL_RST));
		random_phase(310, 0);
		drain();

		$display("Covered %0d requests (%0d clears, %0d zero divisors), %0d results checked,",
			sb.n_req, sb.n_clear, sb.n_fault, sb.n_res);
		$display("%0d votes with agreement, over six register settings.", sb.n_voted);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire
